// File: rtl/ofmp_pkg.sv
// Shared types, codes and character constants for the order feed message parser.
package ofmp_pkg;

    localparam int DEF_LENGTH_COUNTER_BITS = 11;

    localparam logic [7:0] CH_ADD    = 8'h4E; // N
    localparam logic [7:0] CH_MOD    = 8'h4D; // M
    localparam logic [7:0] CH_REM    = 8'h52; // R
    localparam logic [7:0] CH_TRADE  = 8'h58; // X
    localparam logic [7:0] CH_SELL   = 8'h53; // S
    localparam logic [7:0] CH_BUY    = 8'h42; // B
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_ADD   = 3'd1;
    localparam logic [2:0] K_MOD   = 3'd2;
    localparam logic [2:0] K_REM   = 3'd3;
    localparam logic [2:0] K_TRADE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_TYPE     = 3'd2;
    localparam logic [2:0] ST_PRODUCT  = 3'd3;
    localparam logic [2:0] ST_BAD_DATA = 3'd4;

    localparam logic [1:0] CFG_MAX_LEN   = 2'd0;
    localparam logic [1:0] CFG_MAX_SIZE  = 2'd1;
    localparam logic [1:0] CFG_MAX_PRICE = 2'd2;

    // token flag bit positions
    localparam int TF_IN    = 0;
    localparam int TF_DIGIT = 1;
    localparam int TF_NEG   = 2;
    localparam int TF_DOT   = 3;
    localparam int TF_OVF   = 4;

    typedef enum logic [2:0] {
        F_TYPE  = 3'd0,
        F_PROD  = 3'd1,
        F_ORDER = 3'd2,
        F_SIDE  = 3'd3,
        F_SIZE  = 3'd4,
        F_PRICE = 3'd5,
        F_DONE  = 3'd6
    } field_t;

    typedef struct packed {
        logic        [9:0]  len_limit;
        logic        [31:0] size_limit;
        logic        [31:0] price_limit;
    } cfg_t;

    typedef struct packed {
        logic        [2:0]  msg_kind;
        logic        [2:0]  status;
        logic signed [31:0] product_id;
        logic        [63:0] order_id;
        logic               side;
        logic        [31:0] quantity;
        logic        [31:0] price_cents;
    } res_t;

    function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage

// File: rtl/ofmp_req_if.sv
// Request channel: one message byte per request.
interface ofmp_req_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  msg_byte;
    logic               end_of_message;
    logic signed [31:0] preset_product_id;

    modport source (output valid, msg_byte, end_of_message, preset_product_id, input ready);
    modport sink   (input valid, msg_byte, end_of_message, preset_product_id, output ready);
endinterface

// File: rtl/ofmp_res_if.sv
// Result channel: one parsed message per result.
interface ofmp_res_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  msg_kind;
    logic        [2:0]  status;
    logic signed [31:0] product_id;
    logic        [63:0] order_id;
    logic               side;
    logic        [31:0] quantity;
    logic        [31:0] price_cents;

    modport source (output valid, msg_kind, status, product_id, order_id, side, quantity,
                    price_cents, input ready);
    modport sink   (input valid, msg_kind, status, product_id, order_id, side, quantity,
                    price_cents, output ready);
endinterface

// File: rtl/order_feed_message_parser.sv
// Order feed message parser top: input register, byte parser, result register.
// An end byte is held in the input register; its result is registered in the result register once the slot is free.
// Throughput: one byte request per cycle back to back; parser state updates once per byte.
// Only an end byte waits, and only while the result register is full and not being taken.
// Reset (rst_n, async, active low) clears both valid flags and all parser state and restores
// the configuration defaults (length 1023, size and price limits all ones).
module order_feed_message_parser
    import ofmp_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = DEF_LENGTH_COUNTER_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    ofmp_req_if.sink    request,
    ofmp_res_if.source  result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    cfg_t cfg;
    res_t res;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic        [7:0]  byte_reg;
    logic               eom_reg;
    logic signed [31:0] preset_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg;

    logic out_free;
    logic step;

    ofmp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A byte moves on unless it closes a message and the result slot is still full.
    assign out_free = !out_valid_reg || result.ready;
    assign step     = in_valid_reg && (!eom_reg || out_free);
    assign request.ready = !in_valid_reg || step;

    ofmp_parser #(
        .LENGTH_COUNTER_BITS (LENGTH_COUNTER_BITS)
    ) u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .msg_byte          (byte_reg),
        .end_of_message    (eom_reg),
        .preset_product_id (preset_reg),
        .cfg               (cfg),
        .res               (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (request.ready)
            in_valid_next = request.valid;

        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (step && eom_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            byte_reg   <= request.msg_byte;
            eom_reg    <= request.end_of_message;
            preset_reg <= request.preset_product_id;
        end
        if (step && eom_reg)
            res_reg <= res;
    end

    assign result.valid       = out_valid_reg;
    assign result.msg_kind    = res_reg.msg_kind;
    assign result.status      = res_reg.status;
    assign result.product_id  = res_reg.product_id;
    assign result.order_id    = res_reg.order_id;
    assign result.side        = res_reg.side;
    assign result.quantity    = res_reg.quantity;
    assign result.price_cents = res_reg.price_cents;

endmodule

// File: rtl/ofmp_cfg_regs.sv
// Configuration register bank.
module ofmp_cfg_regs
    import ofmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_LEN:   cfg_next.len_limit   = cfg_wdata[9:0];
                CFG_MAX_SIZE:  cfg_next.size_limit  = cfg_wdata;
                CFG_MAX_PRICE: cfg_next.price_limit = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.len_limit   <= 10'h3FF;
            cfg_reg.size_limit  <= 32'hFFFF_FFFF;
            cfg_reg.price_limit <= 32'hFFFF_FFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ofmp_parser.sv
// Per-byte token parser: accumulators, field sequencing and result assembly.
module ofmp_parser
    import ofmp_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = DEF_LENGTH_COUNTER_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic        [7:0]  msg_byte,
    input  logic               end_of_message,
    input  logic signed [31:0] preset_product_id,
    input  cfg_t               cfg,
    output res_t               res
);

    localparam int CW = (LENGTH_COUNTER_BITS > 10) ? LENGTH_COUNTER_BITS : 10;
    localparam logic [LENGTH_COUNTER_BITS-1:0] CNT_MAX = '1;

    field_t                         fld_reg, fld_next;
    logic [LENGTH_COUNTER_BITS-1:0] cnt_reg, cnt_next;
    logic [2:0]                     kind_reg, kind_next;
    logic [2:0]                     err_reg, err_next;
    logic [31:0]                    prod_reg, prod_next;
    logic [63:0]                    order_reg, order_next;
    logic [31:0]                    size_reg, size_next;
    logic [31:0]                    price_reg, price_next;
    logic [1:0]                     frac_reg, frac_next;
    logic                           side_reg, side_next;
    logic [4:0]                     flags_reg, flags_next;

    logic        is_dig;
    logic        first;
    logic        fin;
    logic [4:0]  f;
    logic [3:0]  d;
    logic [35:0] prod_w;
    logic [35:0] size_w;
    logic [35:0] price_w;
    logic [67:0] order_w;
    logic [38:0] cents;
    logic [2:0]  st;
    logic        mr;

    always_comb
    begin
        fld_next   = fld_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        err_next   = err_reg;
        prod_next  = prod_reg;
        order_next = order_reg;
        size_next  = size_reg;
        price_next = price_reg;
        frac_next  = frac_reg;
        side_next  = side_reg;
        flags_next = flags_reg;
        fin        = 1'b0;
        f          = '0;
        first      = 1'b0;
        res        = '0;
        st         = ST_OK;
        mr         = 1'b0;
        cents      = '0;
        is_dig     = (msg_byte >= CH_ZERO) && (msg_byte <= CH_NINE);
        d          = 4'(msg_byte - CH_ZERO);
        prod_w     = ({4'b0, prod_reg} << 3) + ({4'b0, prod_reg} << 1) + {32'b0, d};
        size_w     = ({4'b0, size_reg} << 3) + ({4'b0, size_reg} << 1) + {32'b0, d};
        price_w    = ({4'b0, price_reg} << 3) + ({4'b0, price_reg} << 1) + {32'b0, d};
        order_w    = ({4'b0, order_reg} << 3) + ({4'b0, order_reg} << 1) + {64'b0, d};

        if (step)
        begin
            if (cnt_reg != CNT_MAX)
                cnt_next = cnt_reg + 1'b1;

            // byte handling
            if (fld_reg < F_DONE)
            begin
                if (fld_reg == F_PRICE)
                begin
                    if (msg_byte == CH_SPACE)
                    begin
                        fin = flags_reg[TF_IN];
                    end
                    else
                    begin
                        flags_next[TF_IN] = 1'b1;
                        if (is_dig)
                        begin
                            if (!(flags_reg[TF_DOT] && frac_reg >= 2'd2))
                            begin
                                if (!flags_reg[TF_OVF])
                                begin
                                    price_next = price_w[31:0];
                                    if (price_w[35:32] != 4'd0)
                                        flags_next[TF_OVF] = 1'b1;
                                end
                                flags_next[TF_DIGIT] = 1'b1;
                                if (flags_reg[TF_DOT])
                                    frac_next = frac_reg + 2'd1;
                            end
                        end
                        else if (msg_byte == CH_DOT && !flags_reg[TF_DOT])
                        begin
                            flags_next[TF_DOT] = 1'b1;
                        end
                        else
                        begin
                            err_next = first_err(err_reg, ST_BAD_DATA);
                            fld_next = F_DONE;
                        end
                    end
                end
                else if (msg_byte == CH_COMMA)
                begin
                    fin = flags_reg[TF_IN];
                end
                else
                begin
                    first = !flags_reg[TF_IN];
                    flags_next[TF_IN] = 1'b1;
                    case (fld_reg)
                        F_TYPE:
                        begin
                            if (first)
                            begin
                                case (msg_byte)
                                    CH_ADD:   kind_next = K_ADD;
                                    CH_MOD:   kind_next = K_MOD;
                                    CH_REM:   kind_next = K_REM;
                                    CH_TRADE: kind_next = K_TRADE;
                                    default:
                                    begin
                                        kind_next = K_NONE;
                                        fld_next  = F_DONE;
                                    end
                                endcase
                            end
                        end
                        F_PROD:
                        begin
                            if (first && (msg_byte == CH_MINUS || msg_byte == CH_PLUS))
                            begin
                                if (msg_byte == CH_MINUS)
                                    flags_next[TF_NEG] = 1'b1;
                            end
                            else if (is_dig)
                            begin
                                flags_next[TF_DIGIT] = 1'b1;
                                if (!flags_reg[TF_OVF])
                                begin
                                    prod_next = prod_w[31:0];
                                    if (prod_w > 36'h0_8000_0000)
                                        flags_next[TF_OVF] = 1'b1;
                                end
                            end
                            else
                            begin
                                err_next = first_err(err_reg, ST_PRODUCT);
                                fld_next = F_DONE;
                            end
                        end
                        F_ORDER:
                        begin
                            if (!is_dig)
                            begin
                                err_next = first_err(err_reg, ST_BAD_DATA);
                                fld_next = F_DONE;
                            end
                            else
                            begin
                                flags_next[TF_DIGIT] = 1'b1;
                                if (!flags_reg[TF_OVF])
                                begin
                                    if (order_w[67:64] != 4'd0)
                                        flags_next[TF_OVF] = 1'b1;
                                    else
                                        order_next = order_w[63:0];
                                end
                            end
                        end
                        F_SIDE:
                        begin
                            if (first)
                            begin
                                if (msg_byte == CH_SELL)
                                    side_next = 1'b1;
                                else if (msg_byte == CH_BUY)
                                    side_next = 1'b0;
                                else
                                begin
                                    err_next = first_err(err_reg, ST_BAD_DATA);
                                    fld_next = F_DONE;
                                end
                            end
                        end
                        F_SIZE:
                        begin
                            if (!is_dig)
                            begin
                                err_next = first_err(err_reg, ST_BAD_DATA);
                                fld_next = F_DONE;
                            end
                            else
                            begin
                                flags_next[TF_DIGIT] = 1'b1;
                                if (!flags_reg[TF_OVF])
                                begin
                                    size_next = size_w[31:0];
                                    if (size_w[35:32] != 4'd0)
                                        flags_next[TF_OVF] = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            fld_next = fld_reg;
                        end
                    endcase
                end
            end

            // open token closed by the end of the message
            if (end_of_message && fld_next < F_DONE && flags_next[TF_IN])
                fin = 1'b1;

            if (fin)
            begin
                f = flags_next;
                flags_next = '0;
                case (fld_next)
                    F_TYPE:
                    begin
                        fld_next = (kind_next == K_MOD || kind_next == K_REM) ? F_ORDER : F_PROD;
                    end
                    F_PROD:
                    begin
                        if (!f[TF_DIGIT] || f[TF_OVF])
                        begin
                            err_next = first_err(err_next, ST_PRODUCT);
                            fld_next = F_DONE;
                        end
                        else if (f[TF_NEG] && kind_next == K_ADD && prod_next != 32'd0)
                        begin
                            err_next = first_err(err_next, ST_PRODUCT);
                            fld_next = F_DONE;
                        end
                        else if (!f[TF_NEG] && prod_next > 32'h7FFF_FFFF)
                        begin
                            err_next = first_err(err_next, ST_PRODUCT);
                            fld_next = F_DONE;
                        end
                        else
                        begin
                            if (f[TF_NEG])
                                prod_next = 32'd0 - prod_next;
                            fld_next = (kind_next == K_ADD) ? F_ORDER : F_SIZE;
                        end
                    end
                    F_ORDER:
                    begin
                        if (!f[TF_DIGIT] || f[TF_OVF])
                        begin
                            err_next = first_err(err_next, ST_BAD_DATA);
                            fld_next = F_DONE;
                        end
                        else
                            fld_next = F_SIDE;
                    end
                    F_SIDE:
                    begin
                        fld_next = F_SIZE;
                    end
                    F_SIZE:
                    begin
                        if (!f[TF_DIGIT] || f[TF_OVF] || (kind_next != K_TRADE &&
                            (size_next == 32'd0 || size_next > cfg.size_limit)))
                        begin
                            err_next = first_err(err_next, ST_BAD_DATA);
                            fld_next = F_DONE;
                        end
                        else
                            fld_next = F_PRICE;
                    end
                    F_PRICE:
                    begin
                        case (frac_next)
                            2'd0:    cents = ({7'b0, price_next} << 6) +
                                             ({7'b0, price_next} << 5) +
                                             ({7'b0, price_next} << 2);
                            2'd1:    cents = ({7'b0, price_next} << 3) +
                                             ({7'b0, price_next} << 1);
                            default: cents = {7'b0, price_next};
                        endcase
                        if (!f[TF_DIGIT] || f[TF_OVF] || cents[38:32] != 7'd0 ||
                            cents[31:0] > cfg.price_limit)
                        begin
                            err_next = first_err(err_next, ST_BAD_DATA);
                            fld_next = F_DONE;
                        end
                        else
                        begin
                            price_next = cents[31:0];
                            fld_next   = F_DONE;
                        end
                    end
                    default:
                    begin
                        fld_next = fld_next;
                    end
                endcase
            end

            if (end_of_message)
            begin
                // message ended with fields still missing
                if (fld_next < F_DONE && kind_next != K_NONE)
                begin
                    err_next = first_err(err_next,
                                         (fld_next == F_PROD) ? ST_PRODUCT : ST_BAD_DATA);
                end

                mr = (kind_next == K_MOD) || (kind_next == K_REM);
                if (CW'(cnt_next) > CW'(cfg.len_limit))
                    st = ST_LENGTH;
                else if (kind_next == K_NONE)
                    st = ST_TYPE;
                else if (mr && preset_product_id[31])
                    st = ST_PRODUCT;
                else
                    st = err_next;

                res.status = st;
                if (st != ST_LENGTH && st != ST_TYPE)
                    res.msg_kind = kind_next;
                if (st == ST_OK)
                begin
                    res.product_id  = mr ? preset_product_id : $signed(prod_next);
                    if (kind_next != K_TRADE)
                    begin
                        res.order_id = order_next;
                        res.side     = side_next;
                    end
                    res.quantity    = size_next;
                    res.price_cents = price_next;
                end

                fld_next   = F_TYPE;
                cnt_next   = '0;
                kind_next  = K_NONE;
                err_next   = ST_OK;
                prod_next  = '0;
                order_next = '0;
                size_next  = '0;
                price_next = '0;
                frac_next  = '0;
                side_next  = 1'b0;
                flags_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_reg   <= F_TYPE;
            cnt_reg   <= '0;
            kind_reg  <= K_NONE;
            err_reg   <= ST_OK;
            prod_reg  <= '0;
            order_reg <= '0;
            size_reg  <= '0;
            price_reg <= '0;
            frac_reg  <= '0;
            side_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            fld_reg   <= fld_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
            prod_reg  <= prod_next;
            order_reg <= order_next;
            size_reg  <= size_next;
            price_reg <= price_next;
            frac_reg  <= frac_next;
            side_reg  <= side_next;
            flags_reg <= flags_next;
        end
    end

endmodule
